FILE: design/vrra_pkg.sv
`default_nettype none

package vrra_pkg;

  localparam int unsigned RING_UNITS_DEF   = 1024;
  localparam int unsigned HEADER_UNITS_DEF = 3;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned SIZE_W   = 10;
  localparam int unsigned OFF_W    = 10;
  localparam int unsigned CAP_W    = 11;
  localparam int unsigned TAG_W    = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RESERVE = 2'd0,
    FUNC_COMMIT  = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [TAG_W-1:0] {
    TAG_COMMITTED = 2'd0,
    TAG_BUSY      = 2'd1,
    TAG_END       = 2'd2
  } tag_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_READY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WRAP,
    S_RESKIP
  } state_e;

  typedef struct packed {
    func_e             func;
    logic [SIZE_W-1:0] payload_units;
    logic [OFF_W-1:0]  record_offset;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
  } res_t;

endpackage

`default_nettype wire

FILE: design/vrra_if.sv
`default_nettype none

interface vrra_in_if import vrra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SIZE_W-1:0] payload_units;
  logic [OFF_W-1:0]  record_offset;

  modport source (output valid, func, payload_units, record_offset, input ready);
  modport sink   (input valid, func, payload_units, record_offset, output ready);
endinterface

interface vrra_out_if import vrra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    record_offset_res;
  logic [SIZE_W-1:0]   record_size;

  modport source (output valid, status, record_offset_res, record_size, input ready);
  modport sink   (input valid, status, record_offset_res, record_size, output ready);
endinterface

interface vrra_cfg_if import vrra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_units;

  modport source (output valid, capacity_units, input ready);
  modport sink   (input valid, capacity_units, output ready);
endinterface

`default_nettype wire

FILE: design/variable_record_ring_allocator.sv
// An input beat is taken in idle as a header is read; reserve, commit, read and empty/full
// results form in the execute state, or in the wrap or reskip state for a reserve that
// wraps or a read that skips an end tag, and wait for the result register. Items go one
// at a time, paced by the registered read of the header memory that every item reads or
// writes before it finishes; the result register lets the next item in while a beat waits.
// Reset: indices to zero, capacity to 1024; header memory holds no reset and needs no clear.
`default_nettype none

module variable_record_ring_allocator import vrra_pkg::*; #(
  parameter int unsigned RING_UNITS   = RING_UNITS_DEF,
  parameter int unsigned HEADER_UNITS = HEADER_UNITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  vrra_in_if.sink     in_i,
  vrra_out_if.source  out_o,
  vrra_cfg_if.sink    cfg_i
);

  logic [CAP_W-1:0] cap_q, cap_d;
  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;
  req_t             req;
  res_t             res;
  logic             res_valid;
  logic             res_ready;

  assign req = '{func:          func_e'(in_i.func),
                 payload_units: in_i.payload_units,
                 record_offset: in_i.record_offset};

  vrra_seq #(
    .RING_UNITS   (RING_UNITS),
    .HEADER_UNITS (HEADER_UNITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (in_i.ready),
    .req_i       (req),
    .cap_i       (cap_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign cfg_i.ready = 1'b1;
  assign cap_d       = cfg_i.valid ? cfg_i.capacity_units : cap_q;

  // take a new result when the register is empty or its beat leaves now
  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      res_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status            = res_q.status;
  assign out_o.record_offset_res = res_q.offset;
  assign out_o.record_size       = res_q.size;

endmodule

`default_nettype wire

FILE: design/vrra_ram.sv
`default_nettype none

module vrra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/vrra_seq.sv
`default_nettype none

module vrra_seq import vrra_pkg::*; #(
  parameter int unsigned RING_UNITS   = RING_UNITS_DEF,
  parameter int unsigned HEADER_UNITS = HEADER_UNITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  input  wire req_t             req_i,
  input  wire logic [CAP_W-1:0] cap_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output res_t                  res_o
);

  localparam int unsigned AW = $clog2(RING_UNITS);
  localparam int unsigned CW = $clog2(RING_UNITS + 1);
  localparam int unsigned SW = ((CW > CAP_W) ? CW : CAP_W) + 1;

  state_e            state_q, state_d;
  req_t              op_q, op_d;
  logic [AW-1:0]     ri_q, ri_d;
  logic [AW-1:0]     wi_q, wi_d;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              tag_we;
  logic              size_we;
  logic [AW-1:0]     wr_addr;
  logic [TAG_W-1:0]  wr_tag;
  logic [SIZE_W-1:0] wr_size;
  logic [TAG_W-1:0]  tag_rd;
  logic [SIZE_W-1:0] size_rd;

  logic [SW-1:0]     cap_s;
  logic [SW-1:0]     ri_s;
  logic [SW-1:0]     wi_s;
  logic [SW-1:0]     needed;
  logic [SW-1:0]     fst;
  logic [SW-1:0]     snd;
  logic              fit;
  logic              wrap;
  logic              roff_ok;
  logic              eval_en;
  logic              ev_not_ready;
  logic [SW-1:0]     ev_next;
  logic              ev_drain;

  vrra_ram #(
    .WIDTH (TAG_W),
    .DEPTH (RING_UNITS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_tag),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (tag_rd)
  );

  vrra_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (RING_UNITS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_size),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (size_rd)
  );

  // free space ahead of the write index and at the start of the ring
  always_comb begin
    cap_s  = (SW'(cap_i) > SW'(RING_UNITS)) ? SW'(RING_UNITS) : SW'(cap_i);
    ri_s   = SW'(ri_q);
    wi_s   = SW'(wi_q);
    needed = SW'(HEADER_UNITS) + SW'(op_q.payload_units) + SW'(1);
    if (wi_q >= ri_q) begin
      fst = (cap_s > wi_s) ? (cap_s - wi_s) : '0;
      snd = ri_s;
    end else begin
      fst = ri_s - wi_s;
      snd = '0;
    end
    fit     = (fst >= needed);
    wrap    = !fit && (snd >= needed);
    roff_ok = (SW'(op_q.record_offset) < SW'(RING_UNITS));

    ev_not_ready = (tag_rd == TAG_BUSY) || (tag_rd == TAG_END);
    ev_next      = ri_s + SW'(HEADER_UNITS) + SW'(size_rd);
    ev_drain     = (ev_next == wi_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ri_q    <= '0;
      wi_q    <= '0;
    end else begin
      state_q <= state_d;
      ri_q    <= ri_d;
      wi_q    <= wi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ri_d        = ri_q;
    wi_d        = wi_q;
    req_ready_o = (state_q == S_IDLE);
    rd_en       = 1'b0;
    rd_addr     = ri_q;
    tag_we      = 1'b0;
    size_we     = 1'b0;
    wr_addr     = wi_q;
    wr_tag      = TAG_BUSY;
    wr_size     = op_q.payload_units;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_OK, offset: '0, size: '0};
    eval_en     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d  = req_i;
          rd_en = 1'b1;
          if (req_i.func == FUNC_COMMIT) begin
            rd_addr = AW'(req_i.record_offset);
          end
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_q.func)
          FUNC_RESERVE: begin
            if (fit) begin
              res_valid_o  = 1'b1;
              res_o.offset = OFF_W'(wi_q);
              if (res_ready_i) begin
                tag_we  = 1'b1;
                size_we = 1'b1;
                wi_d    = AW'(wi_s + needed - SW'(1));
                state_d = S_IDLE;
              end
            end else if (wrap) begin
              // mark end of data here, place the record at offset zero next
              tag_we  = 1'b1;
              wr_tag  = TAG_END;
              state_d = S_WRAP;
            end else begin
              res_valid_o  = 1'b1;
              res_o.status = ST_FULL;
              if (res_ready_i) begin
                state_d = S_IDLE;
              end
            end
          end
          FUNC_COMMIT: begin
            res_valid_o = 1'b1;
            if (res_ready_i) begin
              state_d = S_IDLE;
              if (roff_ok && (tag_rd == TAG_BUSY)) begin
                tag_we  = 1'b1;
                wr_addr = AW'(op_q.record_offset);
                wr_tag  = TAG_COMMITTED;
              end
            end
          end
          FUNC_READ: begin
            if (ri_q == wi_q) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_EMPTY;
              if (res_ready_i) begin
                state_d = S_IDLE;
              end
            end else if (tag_rd == TAG_END) begin
              if (wi_q == '0) begin
                res_valid_o  = 1'b1;
                res_o.status = ST_EMPTY;
                if (res_ready_i) begin
                  ri_d    = '0;
                  state_d = S_IDLE;
                end
              end else begin
                // skip the end tag and fetch the header at offset zero
                ri_d    = '0;
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = S_RESKIP;
              end
            end else begin
              eval_en = 1'b1;
            end
          end
          default: begin
            res_valid_o = 1'b1;
            if (res_ready_i) begin
              state_d = S_IDLE;
            end
          end
        endcase
      end
      S_WRAP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          tag_we  = 1'b1;
          size_we = 1'b1;
          wr_addr = '0;
          wi_d    = AW'(needed - SW'(1));
          state_d = S_IDLE;
        end
      end
      S_RESKIP: begin
        eval_en = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // pop the oldest record at the read index, or report it not ready
    if (eval_en) begin
      res_valid_o = 1'b1;
      if (ev_not_ready) begin
        res_o.status = ST_NOT_READY;
      end else begin
        res_o.offset = OFF_W'(ri_q);
        res_o.size   = size_rd;
      end
      if (res_ready_i) begin
        state_d = S_IDLE;
        if (!ev_not_ready) begin
          if (ev_drain) begin
            ri_d = '0;
            wi_d = '0;
          end else begin
            ri_d = AW'(ev_next);
          end
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && (tag_we || size_we) && (rd_addr == wr_addr)))
    else $error("header read and write to the same slot in one cycle");

  a_reskip_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESKIP) |-> ((ri_q == '0) && (wi_q != '0)))
    else $error("end-tag skip left the read index off zero");

  a_wrap_from_reserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRAP) |-> ((op_q.func == FUNC_RESERVE) &&
      (($past(state_q) == S_EXEC) || ($past(state_q) == S_WRAP))))
    else $error("wrap step without a reserve");

  a_drain_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eval_en && res_ready_i && !ev_not_ready && ev_drain) |=>
      ((ri_q == '0) && (wi_q == '0)))
    else $error("indices not returned to zero after the store drained");
`endif

endmodule

`default_nettype wire
